// ===== rtl/axis_angle_vector_rotate_core_assert.svh =====
// Assertion macros shared by the checker of the rotation core.
`ifndef AXIS_ANGLE_VECTOR_ROTATE_CORE_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define AAVR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rotation core check failed");

// Next-cycle implication, clocked on clk and held off during reset.
`define AAVR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rotation core check failed");

`endif

// ===== rtl/aavr_pkg.sv =====
// Package of the axis-angle rotation core: formats, constants and arctangent table.
package aavr_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int STEP_W       = $clog2(ATAN_LEN);
	localparam int CW           = 34;

	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30         = 34'sd1073741824;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic               flip;
	} payload_t;

	function automatic logic signed [CW-1:0] atan_turn(input logic [STEP_W-1:0] idx);
		logic signed [CW-1:0] r;
		unique case (idx)
			5'd0:    r = 34'sh020000000;
			5'd1:    r = 34'sh012E4051E;
			5'd2:    r = 34'sh009FB385B;
			5'd3:    r = 34'sh0051111D4;
			5'd4:    r = 34'sh0028B0D43;
			5'd5:    r = 34'sh00145D7E1;
			5'd6:    r = 34'sh000A2F61E;
			5'd7:    r = 34'sh000517C55;
			5'd8:    r = 34'sh00028BE53;
			5'd9:    r = 34'sh000145F2F;
			5'd10:   r = 34'sh0000A2F98;
			5'd11:   r = 34'sh0000517CC;
			5'd12:   r = 34'sh000028BE6;
			5'd13:   r = 34'sh0000145F3;
			5'd14:   r = 34'sh000000A2FA;
			5'd15:   r = 34'sh00000517D;
			5'd16:   r = 34'sh0000028BE;
			5'd17:   r = 34'sh00000145F;
			5'd18:   r = 34'sh000000A30;
			5'd19:   r = 34'sh000000518;
			5'd20:   r = 34'sh00000028C;
			5'd21:   r = 34'sh000000146;
			5'd22:   r = 34'sh0000000A3;
			5'd23:   r = 34'sh000000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/aavr_cordic_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation plus the carried word.
module aavr_cordic_cell import aavr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [STEP_W-1:0] step,
	input  logic              vld_in,
	input  cordic_t           st_in,
	input  payload_t          pl_in,
	output logic              vld_out,
	output cordic_t           st_out,
	output payload_t          pl_out
);

	logic     vld_q;
	cordic_t  st_q;
	payload_t pl_q;
	cordic_t  st_nxt;

	always_comb begin
		if (!st_in.z[CW-1]) begin
			st_nxt.x = st_in.x - (st_in.y >>> step);
			st_nxt.y = st_in.y + (st_in.x >>> step);
			st_nxt.z = st_in.z - atan_turn(step);
		end else begin
			st_nxt.x = st_in.x + (st_in.y >>> step);
			st_nxt.y = st_in.y - (st_in.x >>> step);
			st_nxt.z = st_in.z + atan_turn(step);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q <= st_nxt;
			pl_q <= pl_in;
		end
	end

	assign vld_out = vld_q;
	assign st_out  = st_q;
	assign pl_out  = pl_q;

endmodule

// ===== rtl/aavr_matrix.sv =====
// Rodrigues matrix build and matrix-vector product, rounded and saturated.
module aavr_matrix import aavr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld_in,
	input  cordic_t            st_in,
	input  payload_t           pl_in,
	output logic               vld_out,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z
);

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [CW-1:0] c_s1, t_s1, s_s1;
	logic signed [15:0]   a_s1 [3];
	logic signed [31:0]   aa_s1 [3][3];
	logic signed [31:0]   v_s1 [3], v_s2 [3], v_s3 [3];
	logic signed [65:0]   tp_s2 [3][3];
	logic signed [49:0]   sa_s2 [3];
	logic signed [63:0]   c30_s2;
	logic signed [34:0]   m_s3 [3][3];
	logic signed [66:0]   p_s4 [3][3];
	logic signed [31:0]   res_s5 [3];
	logic signed [CW-1:0] c_nxt;
	logic signed [15:0]   a_in [3];
	logic signed [31:0]   v_in [3];
	logic signed [66:0]   e_nxt [3][3];
	logic signed [66:0]   extra [3][3];
	logic signed [68:0]   acc [3];
	logic signed [40:0]   acc_sh [3];
	logic signed [31:0]   sat_nxt [3];

	always_comb begin
		c_nxt   = pl_in.flip ? -st_in.x : st_in.x;
		a_in[0] = pl_in.ax;
		a_in[1] = pl_in.ay;
		a_in[2] = pl_in.az;
		v_in[0] = pl_in.vx;
		v_in[1] = pl_in.vy;
		v_in[2] = pl_in.vz;
	end

	// diagonal gets cosine, others sine times third axis part, negated at k = r+1 mod 3
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (r == k) begin
					extra[r][k] = 67'(c30_s2);
				end else if (k == ((r + 1) % 3)) begin
					extra[r][k] = -(67'(sa_s2[3-r-k]) <<< 15);
				end else begin
					extra[r][k] = 67'(sa_s2[3-r-k]) <<< 15;
				end
				e_nxt[r][k] = 67'(tp_s2[r][k]) + extra[r][k] + 67'sd2147483648;
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r]    = 69'(p_s4[r][0]) + 69'(p_s4[r][1]) + 69'(p_s4[r][2])
				+ 69'sd134217728;
			acc_sh[r] = 41'(acc[r] >>> 28);
			if (acc_sh[r] > 41'sd2147483647) begin
				sat_nxt[r] = 32'sh7FFFFFFF;
			end else if (acc_sh[r] < -41'sd2147483648) begin
				sat_nxt[r] = 32'sh80000000;
			end else begin
				sat_nxt[r] = 32'(acc_sh[r]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= c_nxt;
			t_s1 <= ONE_Q30 - c_nxt;
			s_s1 <= pl_in.flip ? -st_in.y : st_in.y;
			for (int r = 0; r < 3; r++) begin
				a_s1[r] <= a_in[r];
				v_s1[r] <= v_in[r];
				v_s2[r] <= v_s1[r];
				v_s3[r] <= v_s2[r];
				sa_s2[r] <= s_s1 * a_s1[r];
				res_s5[r] <= sat_nxt[r];
				for (int k = 0; k < 3; k++) begin
					aa_s1[r][k] <= a_in[r] * a_in[k];
					tp_s2[r][k] <= t_s1 * aa_s1[r][k];
					m_s3[r][k]  <= 35'(e_nxt[r][k] >>> 32);
					p_s4[r][k]  <= m_s3[r][k] * v_s3[k];
				end
			end
			c30_s2 <= $signed({c_s1, 30'b0});
		end
	end

	assign vld_out = vld_s5;
	assign res_x   = res_s5[0];
	assign res_y   = res_s5[1];
	assign res_z   = res_s5[2];

endmodule

// ===== rtl/axis_angle_vector_rotate_core.sv =====
// Axis-angle vector rotation core: one word in and one word out per cycle while the
// output is not stalled. The angle is folded into the half turn, then a chain of
// CORDIC cells (one micro-rotation each) yields sine and cosine, then five matrix
// stages build the Rodrigues matrix and apply it to the vector; the last of those
// stages is the output register. The axis is used as given and is not normalised.
// The whole pipeline advances together; a stall on the output with a word waiting
// holds every stage and raises in_stall in the same cycle, while an empty output
// slot lets words keep flowing.
module axis_angle_vector_rotate_core import aavr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic        [15:0] turn_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);

	logic                 adv;
	logic signed [CW-1:0] z_raw;
	logic                 vld_c [CORDIC_STEPS+1];
	cordic_t              st_c  [CORDIC_STEPS+1];
	payload_t             pl_c  [CORDIC_STEPS+1];

	// advance unless a finished word is held at the output
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// fold angles beyond a quarter turn back by a half turn; negate the results later
	always_comb begin
		z_raw      = CW'($signed({turn_angle, 16'b0}));
		vld_c[0]   = in_valid;
		st_c[0].x  = CORDIC_GAIN_Q30;
		st_c[0].y  = '0;
		pl_c[0].ax = axis_x;
		pl_c[0].ay = axis_y;
		pl_c[0].az = axis_z;
		pl_c[0].vx = vec_x;
		pl_c[0].vy = vec_y;
		pl_c[0].vz = vec_z;
		if (z_raw > ONE_Q30) begin
			st_c[0].z    = z_raw - (ONE_Q30 <<< 1);
			pl_c[0].flip = 1'b1;
		end else if (z_raw < -ONE_Q30) begin
			st_c[0].z    = z_raw + (ONE_Q30 <<< 1);
			pl_c[0].flip = 1'b1;
		end else begin
			st_c[0].z    = z_raw;
			pl_c[0].flip = 1'b0;
		end
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		aavr_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.step    (STEP_W'(g)),
			.vld_in  (vld_c[g]),
			.st_in   (st_c[g]),
			.pl_in   (pl_c[g]),
			.vld_out (vld_c[g+1]),
			.st_out  (st_c[g+1]),
			.pl_out  (pl_c[g+1])
		);
	end

	aavr_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (vld_c[CORDIC_STEPS]),
		.st_in   (st_c[CORDIC_STEPS]),
		.pl_in   (pl_c[CORDIC_STEPS]),
		.vld_out (out_valid),
		.res_x   (out_x),
		.res_y   (out_y),
		.res_z   (out_z)
	);

endmodule

// ===== rtl/aavr_checker.sv =====
// Port-level checker of the rotation core and its bind.
`include "axis_angle_vector_rotate_core_assert.svh"

module aavr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] out_x,
	input logic [31:0] out_y,
	input logic [31:0] out_z
);

	`AAVR_ASSERT_NOW(a_stall_back, out_valid && out_stall, in_stall)
	`AAVR_ASSERT_NOW(a_empty_takes, !out_valid, !in_stall)
	`AAVR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))

endmodule

bind axis_angle_vector_rotate_core aavr_checker u_aavr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_x     (out_x),
	.out_y     (out_y),
	.out_z     (out_z)
);

// ===== tb/axis_angle_vector_rotate_core_checker.sv =====
// Checker for the rotation core: predicts each rotated word and compares it with the output.
`timescale 1ns / 1ps
module axis_angle_vector_rotate_core_checker import aavr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic        [15:0] turn_angle,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] out_x,
	input  logic signed [31:0] out_y,
	input  logic signed [31:0] out_z,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	localparam longint ARCTAN [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};
	localparam longint UNIT  = 64'sd1073741824;
	localparam longint GAIN  = 64'sd652032874;
	localparam longint HALF  = 64'sd2147483648;

	vec3_t rotated_q[$];

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic vec3_t rotate_vector(input logic signed [15:0] ax, ay, az,
			input logic signed [31:0] vx, vy, vz, input logic [15:0] ang);
		longint a [3];
		longint v [3];
		longint skew [3][3];
		longint mat [3][3];
		longint cx, cy, cz, nx, sn, cs, t, e, acc;
		logic signed [31:0] res [3];
		bit flip;
		vec3_t r;
		a[0] = ax; a[1] = ay; a[2] = az;
		v[0] = vx; v[1] = vy; v[2] = vz;
		cz = longint'($signed({ang, 16'h0000}));
		flip = 1'b0;
		// fold the angle into the half turn about zero; exactly a quarter stays as is
		if (cz > UNIT) begin
			cz -= HALF;
			flip = 1'b1;
		end else if (cz < -UNIT) begin
			cz += HALF;
			flip = 1'b1;
		end
		cx = GAIN;
		cy = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			if (cz >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				cz -= ARCTAN[i];
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				cz += ARCTAN[i];
			end
			cx = nx;
		end
		cs = flip ? -cx : cx;
		sn = flip ? -cy : cy;
		t = UNIT - cs;
		skew[0][0] = 0;     skew[0][1] = -a[2]; skew[0][2] = a[1];
		skew[1][0] = a[2];  skew[1][1] = 0;     skew[1][2] = -a[0];
		skew[2][0] = -a[1]; skew[2][1] = a[0];  skew[2][2] = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				e = t * (a[i] * a[j]);
				if (i == j)
					e += cs * UNIT;
				else
					e += sn * skew[i][j] * 32768;
				mat[i][j] = (e + (64'sd1 <<< 31)) >>> 32;
			end
		for (int i = 0; i < 3; i++) begin
			acc = mat[i][0] * v[0] + mat[i][1] * v[1] + mat[i][2] * v[2];
			res[i] = 32'(clamp32((acc + (64'sd1 <<< 27)) >>> 28));
		end
		r.x = res[0];
		r.y = res[1];
		r.z = res[2];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic signed [31:0] got, want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		vec3_t want;
		if (!arst_n) begin
			rotated_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (rotated_q.size() == 0) begin
					$display("unexpected output word at %0t", $time);
					errors++;
				end else begin
					want = rotated_q.pop_front();
					if (out_x !== want.x)
						report_mismatch("out_x", out_x, want.x);
					if (out_y !== want.y)
						report_mismatch("out_y", out_y, want.y);
					if (out_z !== want.z)
						report_mismatch("out_z", out_z, want.z);
				end
			end
			if (in_valid && !in_stall)
				rotated_q.push_back(rotate_vector(axis_x, axis_y, axis_z,
					vec_x, vec_y, vec_z, turn_angle));
			pending = rotated_q.size();
		end
	end

endmodule

// ===== tb/axis_angle_vector_rotate_core_tb.sv =====
// Testbench top of the rotation core: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module axis_angle_vector_rotate_core_tb;
	import aavr_pkg::*;

	localparam int RANDOM_WORDS = 750;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES  = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] axis_x = '0;
	logic signed [15:0] axis_y = '0;
	logic signed [15:0] axis_z = '0;
	logic signed [31:0] vec_x = '0;
	logic signed [31:0] vec_y = '0;
	logic signed [31:0] vec_z = '0;
	logic        [15:0] turn_angle = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	int                 errors;
	int                 pending;

	// quiet: no idling on either side; hold_go asks the receiver for one long hold-off
	bit quiet = 1'b0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	always #10 clk = ~clk;

	axis_angle_vector_rotate_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.axis_x    (axis_x),
		.axis_y    (axis_y),
		.axis_z    (axis_z),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.turn_angle(turn_angle),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z)
	);

	axis_angle_vector_rotate_core_checker u_checker (.*);

	// Receiver: random stalls, one long hold-off on request, none while quiet.
	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1'b1;
		end else
			out_stall = !quiet && ($urandom_range(99) < 19);
	end

	// Watchdog: give up well past the slowest correct run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Offer one word from the falling edge and hold it until it is taken.
	task automatic send_word(input logic signed [15:0] ax, ay, az,
			input logic signed [31:0] vx, vy, vz, input logic [15:0] ang);
		while (!quiet && $urandom_range(99) < 19) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		axis_x     = ax;
		axis_y     = ay;
		axis_z     = az;
		vec_x      = vx;
		vec_y      = vy;
		vec_z      = vz;
		turn_angle = ang;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Axis along one coordinate at full scale, a diagonal with random signs, or fully random (often not unit length).
	task automatic send_random;
		logic signed [15:0] ax, ay, az;
		logic signed [31:0] vx, vy, vz;
		int kind;
		kind = $urandom_range(9);
		ax = 16'($urandom);
		ay = 16'($urandom);
		az = 16'($urandom);
		if (kind < 5) begin
			ax = '0; ay = '0; az = '0;
			case ($urandom_range(2))
				0: ax = $urandom_range(1) ? 16'sh7FFF : 16'sh8001;
				1: ay = $urandom_range(1) ? 16'sh7FFF : 16'sh8001;
				default: az = $urandom_range(1) ? 16'sh7FFF : 16'sh8001;
			endcase
		end else if (kind < 7) begin
			// roughly unit diagonal-ish axis: 0.577 in Q1.15 with random signs
			ax = $urandom_range(1) ? 16'sd18919 : -16'sd18919;
			ay = $urandom_range(1) ? 16'sd18919 : -16'sd18919;
			az = $urandom_range(1) ? 16'sd18919 : -16'sd18919;
		end
		vx = $urandom;
		vy = $urandom;
		vz = $urandom;
		if ($urandom_range(3) == 0) begin
			// modest vectors so that most results stay clear of saturation
			vx = $signed(vx) >>> 12;
			vy = $signed(vy) >>> 12;
			vz = $signed(vz) >>> 12;
		end
		send_word(ax, ay, az, vx, vy, vz, 16'($urandom));
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: folding edges of the angle, axis and vector extremes, saturation.
		send_word(16'sh7FFF, '0, '0, 32'sh00010000, 32'sh00010000, 32'sh00010000, 16'h0000);
		send_word('0, 16'sh7FFF, '0, 32'sh00010000, 32'sh00020000, 32'sh00030000, 16'h4000);
		send_word('0, '0, 16'sh7FFF, 32'sh00010000, 32'sh00020000, '0, 16'h4001);
		send_word('0, '0, 16'sh7FFF, 32'sh00010000, 32'sh00020000, '0, 16'h3FFF);
		send_word(16'sh7FFF, '0, '0, '0, 32'sh00010000, '0, 16'h8000);
		send_word(16'sh7FFF, '0, '0, '0, 32'sh00010000, '0, 16'hC000);
		send_word(16'sh7FFF, '0, '0, '0, 32'sh00010000, '0, 16'hBFFF);
		send_word(16'sh7FFF, '0, '0, '0, 32'sh00010000, '0, 16'hC001);
		send_word(16'sh7FFF, '0, '0, '0, 32'sh00010000, '0, 16'hFFFF);
		send_word(16'sh8000, 16'sh8000, 16'sh8000, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF, 16'h2000);
		send_word(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 16'h8000);
		send_word(16'sh8000, 16'sh7FFF, 16'sh8000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 16'h6000);
		send_word('0, '0, '0, 32'sh12345678, 32'shEDCBA987, 32'sh00000001, 16'h1234);
		send_word('0, '0, '0, 32'shFFFFFFFF, 32'sh00000000, 32'sh80000000, 16'h8000);
		send_word(16'sh4000, 16'sh4000, 16'sh4000, 32'sh40000000, 32'shC0000000,
			32'sh00008000, 16'h5555);
		send_word(16'shFFFF, 16'sh0001, 16'shFFFF, 32'sh7FFFFFFF, 32'sh00000001,
			32'shFFFFFFFF, 16'hAAAA);

		// Random with idling.
		for (int i = 0; i < RANDOM_WORDS / 3; i++)
			send_random();

		// Long receiver hold-off while words keep coming: the pipe fills and stalls.
		hold_go = 1'b1;
		for (int i = 0; i < 60; i++)
			send_random();

		// Sender pause until everything has come back.
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);

		// Back-to-back stretch with no idling on either side.
		quiet = 1'b1;
		for (int i = 0; i < 150; i++)
			send_random();
		quiet = 1'b0;

		for (int i = 0; i < RANDOM_WORDS - RANDOM_WORDS / 3 - 210; i++)
			send_random();
		in_valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
